FILE: src/blpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blpw_pkg;

   // coordinate and offset widths
   localparam int COORD_BITS   = 16;
   localparam int OFFSET_BITS  = 26;

   // fixed field widths
   localparam int CLIP_BITS    = 14;
   localparam int PITCH_BITS   = 16;
   localparam int BPP_BITS     = 3;
   localparam int COLOR_BITS   = 24;
   localparam int COUNT_BITS   = 32;
   localparam int OFS_SUM_BITS = 32;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH    = 3'd0,
      CSR_SCREEN_HEIGHT   = 3'd1,
      CSR_ROW_PITCH       = 3'd2,
      CSR_BYTES_PER_PIXEL = 3'd3,
      CSR_DISPLAY_ACTIVE  = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   // pixel size code for 24-bit pixels, everything else is 32-bit
   localparam logic [BPP_BITS-1:0] BPP_24 = 3'd3;

   // control from the top level to the line stepper
   typedef struct packed {
      logic load;
      logic advance;
   } step_ctrl_type;

   // current pixel of the line
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
      logic [COLOR_BITS-1:0]        color;
   } pixel_type;

endpackage

`default_nettype wire

FILE: src/blpw_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

module blpw_stepper (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire blpw_pkg::step_ctrl_type                  ctrl,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]   start_x,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]   start_y,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]   end_x,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]   end_y,
   input  wire logic [blpw_pkg::COLOR_BITS-1:0]          line_color,
   output logic                                          busy,
   output blpw_pkg::pixel_type                           pixel
);

   localparam int CB = blpw_pkg::COORD_BITS;
   localparam int DW = CB + 1;   // delta
   localparam int NW = CB + 2;   // negated delta
   localparam int EW = CB + 3;   // error term
   localparam int TW = CB + 4;   // doubled error term

   logic signed [CB-1:0]             cur_x_ff, cur_x_in;
   logic signed [CB-1:0]             cur_y_ff, cur_y_in;
   logic signed [CB-1:0]             goal_x_ff, goal_y_ff;
   logic [DW-1:0]                    delta_x_ff;
   logic signed [NW-1:0]             neg_delta_y_ff, neg_delta_y_in;
   logic                             step_x_neg_ff, step_y_neg_ff;
   logic signed [EW-1:0]             error_term_ff, error_term_in;
   logic [blpw_pkg::COLOR_BITS-1:0]  held_color_ff;
   logic                             line_busy_ff;

   logic signed [DW-1:0] dx_diff, dy_diff;
   logic [DW-1:0]        dx_abs, dy_abs;
   logic signed [TW-1:0] start_err;
   logic signed [TW-1:0] dx_t, ndy_t, err_t, dbl_t, err_a, err_b;
   logic                 x_move, y_move;
   logic                 at_goal;

   // setup of a new line
   assign dx_diff        = DW'(end_x) - DW'(start_x);
   assign dy_diff        = DW'(end_y) - DW'(start_y);
   assign dx_abs         = dx_diff[DW-1] ? DW'(-dx_diff) : DW'(dx_diff);
   assign dy_abs         = dy_diff[DW-1] ? DW'(-dy_diff) : DW'(dy_diff);
   assign neg_delta_y_in = -$signed({1'b0, dy_abs});
   assign start_err      = TW'($signed({1'b0, dx_abs})) + TW'(neg_delta_y_in);

   // one bresenham step
   assign dx_t   = TW'($signed({1'b0, delta_x_ff}));
   assign ndy_t  = TW'(neg_delta_y_ff);
   assign err_t  = TW'(error_term_ff);
   assign dbl_t  = err_t <<< 1;
   assign x_move = dbl_t >= ndy_t;
   assign y_move = dbl_t <= dx_t;
   assign err_a  = x_move ? err_t + ndy_t : err_t;
   assign err_b  = y_move ? err_a + dx_t : err_a;

   assign error_term_in = EW'(err_b);
   assign cur_x_in = !x_move ? cur_x_ff :
                     (step_x_neg_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1));
   assign cur_y_in = !y_move ? cur_y_ff :
                     (step_y_neg_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1));

   assign at_goal = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_busy_ff <= 1'b0;
      end else if (ctrl.load) begin
         line_busy_ff <= 1'b1;
      end else if (ctrl.advance && at_goal) begin
         line_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cur_x_ff       <= start_x;
         cur_y_ff       <= start_y;
         goal_x_ff      <= end_x;
         goal_y_ff      <= end_y;
         delta_x_ff     <= dx_abs;
         neg_delta_y_ff <= neg_delta_y_in;
         step_x_neg_ff  <= !(start_x < end_x);
         step_y_neg_ff  <= !(start_y < end_y);
         error_term_ff  <= EW'(start_err);
         held_color_ff  <= line_color;
      end else if (ctrl.advance && !at_goal) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         error_term_ff <= error_term_in;
      end
   end

   assign busy        = line_busy_ff;
   assign pixel.x     = cur_x_ff;
   assign pixel.y     = cur_y_ff;
   assign pixel.last  = at_goal;
   assign pixel.color = held_color_ff;

endmodule

`default_nettype wire

FILE: src/bresenham_line_pixel_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// bresenham line pixel writer: a start transaction (func 0) loads both endpoints and the
// color and produces no result; each step transaction (func 1) while a line is busy gives
// one pixel result, the final endpoint flagged as last, after which the line goes idle.
// a step while idle is taken and dropped. each pixel is clipped against the screen size
// and the display-active flag; a visible pixel carries its byte offset
// (y * row_pitch + x * 3 or 4) and the color, and bumps a 32-bit written count.
// throughput is one transaction per clock while results are taken: the error term and
// coordinates update together, and the clip check, offset multiply and output register form
// a short two-stage pipeline behind it. a step result passes through the pixel register
// and then the output register. the pixel register doubles as a skid stage, so a stalled
// result does not block the input until both stages are full. configuration is taken on
// any cycle (csr_ready is always high) but must only be written while the block is idle.
module bresenham_line_pixel_writer (
   input  wire logic                                      clock,
   input  wire logic                                      reset,

   // step / start transactions
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_func,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]    req_start_x,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]    req_start_y,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]    req_end_x,
   input  wire logic signed [blpw_pkg::COORD_BITS-1:0]    req_end_y,
   input  wire logic [blpw_pkg::COLOR_BITS-1:0]           req_line_color,

   // pixel results
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic signed [blpw_pkg::COORD_BITS-1:0]         rsp_pixel_x,
   output logic signed [blpw_pkg::COORD_BITS-1:0]         rsp_pixel_y,
   output logic                                           rsp_write_enable,
   output logic [blpw_pkg::OFFSET_BITS-1:0]               rsp_byte_offset,
   output logic [blpw_pkg::COLOR_BITS-1:0]                rsp_pixel_bytes,
   output logic                                           rsp_last_pixel,
   output logic [blpw_pkg::COUNT_BITS-1:0]                rsp_written_count,

   // configuration writes
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [blpw_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire logic [blpw_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int SB = blpw_pkg::OFS_SUM_BITS;
   localparam int KB = blpw_pkg::CLIP_BITS;

   // configuration registers
   logic [KB-1:0]                     screen_width_ff;
   logic [KB-1:0]                     screen_height_ff;
   logic [blpw_pkg::PITCH_BITS-1:0]   row_pitch_ff;
   logic [blpw_pkg::BPP_BITS-1:0]     bytes_per_pixel_ff;
   logic                              display_active_ff;

   // stepper interface
   blpw_pkg::step_ctrl_type           step_ctrl;
   blpw_pkg::pixel_type               cur_pixel;
   logic                              line_busy;

   // pixel stage
   logic                              s1_valid_ff;
   blpw_pkg::pixel_type               s1_pixel_ff;
   logic                              s1_visible_ff;
   logic                              visible_in;

   // output stage
   logic                                      out_valid_ff;
   logic signed [blpw_pkg::COORD_BITS-1:0]    out_x_ff, out_y_ff;
   logic                                      out_we_ff;
   logic [blpw_pkg::OFFSET_BITS-1:0]          out_offset_ff;
   logic [blpw_pkg::COLOR_BITS-1:0]           out_bytes_ff;
   logic                                      out_last_ff;
   logic [blpw_pkg::COUNT_BITS-1:0]           out_count_ff;

   logic [blpw_pkg::COUNT_BITS-1:0]           count_ff, count_in;

   logic          req_take, out_free, s1_move, s1_load;
   logic [SB-1:0] x_ext, y_ext, x_clip, y_clip, row_term, col_term, offset_sum;
   logic          is_24bit;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff    <= KB'(320);
         screen_height_ff   <= KB'(200);
         row_pitch_ff       <= blpw_pkg::PITCH_BITS'(1280);
         bytes_per_pixel_ff <= blpw_pkg::BPP_BITS'(4);
         display_active_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (blpw_pkg::csr_index_type'(csr_index))
            blpw_pkg::CSR_SCREEN_WIDTH: begin
               screen_width_ff <= csr_wdata[KB-1:0];
            end
            blpw_pkg::CSR_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_wdata[KB-1:0];
            end
            blpw_pkg::CSR_ROW_PITCH: begin
               row_pitch_ff <= csr_wdata[blpw_pkg::PITCH_BITS-1:0];
            end
            blpw_pkg::CSR_BYTES_PER_PIXEL: begin
               bytes_per_pixel_ff <= csr_wdata[blpw_pkg::BPP_BITS-1:0];
            end
            blpw_pkg::CSR_DISPLAY_ACTIVE: begin
               display_active_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   // output register frees when empty or being taken; the pixel stage then moves on
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // a step on an idle line is taken but dropped
   assign s1_load           = req_take && (req_func == blpw_pkg::FUNC_STEP) && line_busy;
   assign step_ctrl.load    = req_take && (req_func == blpw_pkg::FUNC_START);
   assign step_ctrl.advance = s1_load;

   blpw_stepper u_stepper (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (step_ctrl),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .line_color (req_line_color),
      .busy       (line_busy),
      .pixel      (cur_pixel)
   );

   // ---------------------------------------------------------------- clip check
   assign visible_in = display_active_ff &&
                       !cur_pixel.x[blpw_pkg::COORD_BITS-1] &&
                       !cur_pixel.y[blpw_pkg::COORD_BITS-1] &&
                       (SB'($unsigned(cur_pixel.x)) < SB'(screen_width_ff)) &&
                       (SB'($unsigned(cur_pixel.y)) < SB'(screen_height_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pixel_ff   <= cur_pixel;
         s1_visible_ff <= visible_in;
      end
   end

   // ---------------------------------------------------------------- address
   // a visible pixel has both coordinates below the 14-bit clip bounds
   assign x_ext      = SB'($unsigned(s1_pixel_ff.x));
   assign y_ext      = SB'($unsigned(s1_pixel_ff.y));
   assign x_clip     = SB'(x_ext[KB-1:0]);
   assign y_clip     = SB'(y_ext[KB-1:0]);
   assign is_24bit   = bytes_per_pixel_ff == blpw_pkg::BPP_24;
   assign row_term   = y_clip * SB'(row_pitch_ff);
   assign col_term   = is_24bit ? (x_clip << 1) + x_clip : (x_clip << 2);
   assign offset_sum = row_term + col_term;

   assign count_in = count_ff + blpw_pkg::COUNT_BITS'(s1_visible_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            count_ff <= count_in;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_x_ff      <= s1_pixel_ff.x;
         out_y_ff      <= s1_pixel_ff.y;
         out_we_ff     <= s1_visible_ff;
         out_offset_ff <= s1_visible_ff ? offset_sum[blpw_pkg::OFFSET_BITS-1:0] : '0;
         out_bytes_ff  <= s1_visible_ff ? s1_pixel_ff.color : '0;
         out_last_ff   <= s1_pixel_ff.last;
         out_count_ff  <= count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_write_enable  = out_we_ff;
   assign rsp_byte_offset   = out_offset_ff;
   assign rsp_pixel_bytes   = out_bytes_ff;
   assign rsp_last_pixel    = out_last_ff;
   assign rsp_written_count = out_count_ff;

   // ---------------------------------------------------------------- assertions
   // a clipped pixel carries no offset and no color
   a_clipped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> (rsp_byte_offset == '0) && (rsp_pixel_bytes == '0))
      else $error("clipped pixel with nonzero offset or color");

   // the written count moves by at most one per cycle, and only with a visible pixel
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        ((count_ff == $past(count_ff) + 1'b1) && $past(s1_move) &&
                         $past(s1_visible_ff)))
      else $error("written count moved unexpectedly");

   // a pending pixel is kept while the output register is stalled
   a_pixel_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |=> s1_valid_ff && $stable(s1_pixel_ff))
      else $error("pending pixel lost under stall");

   // no input transaction is taken while both stages are full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |-> !req_take)
      else $error("transaction taken with full pipeline");

endmodule

`default_nettype wire
